>>> design/crc16mgc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the CRC-16 message generator and checker.
// No dependencies; every other file of the block refers to this package by scoped names.

package crc16mgc_pkg;

	localparam int DATA_W   = 8;
	localparam int CRC_W    = 16;
	localparam int CMP_W    = 2;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [CRC_W-1:0] POLY_RESET    = 16'h8005;
	localparam logic [CMP_W-1:0] CMP_LEN_RESET = 2'd2;

	// Register index is taken from paddr[2].
	localparam logic REG_POLY    = 1'b0;
	localparam logic REG_CMP_LEN = 1'b1;

	// Compare length codes; anything above CMP_HIGH compares both bytes.
	localparam logic [CMP_W-1:0] CMP_NONE = 2'd0;
	localparam logic [CMP_W-1:0] CMP_HIGH = 2'd1;

	typedef struct packed {
		logic [CRC_W-1:0] poly;
		logic [CMP_W-1:0] cmp_len;
	} cfg_t;

	// Absorb one byte, least significant bit first, into the CRC register.
	function automatic logic [CRC_W-1:0] crc_byte(
		input logic [CRC_W-1:0]  crc,
		input logic [DATA_W-1:0] data,
		input logic [CRC_W-1:0]  poly
	);
		logic [CRC_W-1:0] r;
		logic             fb;
		r = crc;
		for (int i = 0; i < DATA_W; i++) begin
			fb = data[i] ^ r[CRC_W-1];
			r  = {r[CRC_W-2:0], 1'b0} ^ (fb ? poly : '0);
		end
		return r;
	endfunction

	// Compare the leading bytes of the computed CRC with the received one.
	function automatic logic crc_match(
		input logic [CRC_W-1:0] crc,
		input logic [CRC_W-1:0] rx,
		input logic [CMP_W-1:0] cmp_len
	);
		logic hi_ok;
		logic lo_ok;
		hi_ok = (crc[15:8] == rx[15:8]);
		lo_ok = (crc[7:0] == rx[7:0]);
		return (cmp_len == CMP_NONE) || (hi_ok && ((cmp_len == CMP_HIGH) || lo_ok));
	endfunction

endpackage

>>> design/crc16_message_generate_check_top.sv
`timescale 1ns / 1ps
// Top level of the CRC-16 message generator and checker.
// Depends on crc16mgc_pkg, crc16mgc_regs and crc16mgc_core.
//
//  channel  | direction | beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tdata: data_byte, received_crc; tuser: first; tlast
//  m_axis   | out       | tdata: crc_value; tuser: crc_good (one beat per last)
//  apb      | in/out    | 0x0 polynomial, 0x4 compare_length
//
// One byte is accepted per cycle while the input is not stalled; the 8-bit CRC update
// sits between the input register and the result register, so a result is registered
// in the result register once its last byte leaves the input register.
// Reset clears the accumulator, the valid flags and restores the register defaults.
// A stalled result holds a following last byte in the input register, and only then
// is the input stalled; bytes that are not last keep flowing.

module crc16_message_generate_check_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [23:0]                     s_axis_tdata,  // [7:0] data_byte, [23:8] received_crc
	input  logic                            s_axis_tuser,  // [0] first_byte
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [15:0]                     m_axis_tdata,  // [15:0] crc_value
	output logic                            m_axis_tuser,  // [0] crc_good
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [crc16mgc_pkg::APB_AW-1:0] paddr,
	input  logic [crc16mgc_pkg::APB_DW-1:0] pwdata,
	output logic [crc16mgc_pkg::APB_DW-1:0] prdata,
	output logic                            pready
);

	crc16mgc_pkg::cfg_t cfg;

	crc16mgc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crc16mgc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata[7:0]),
		.in_first  (s_axis_tuser),
		.in_last   (s_axis_tlast),
		.in_rx     (s_axis_tdata[23:8]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_crc   (m_axis_tdata),
		.out_ok    (m_axis_tuser)
	);

endmodule

>>> design/crc16mgc_regs.sv
`timescale 1ns / 1ps
// APB-style configuration registers: generator polynomial and compare length.
// Depends on crc16mgc_pkg for widths, reset values and the register index codes.

module crc16mgc_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [crc16mgc_pkg::APB_AW-1:0] paddr,
	input  logic [crc16mgc_pkg::APB_DW-1:0] pwdata,
	output logic [crc16mgc_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	output crc16mgc_pkg::cfg_t              cfg
);

	logic [crc16mgc_pkg::CRC_W-1:0] poly_q;
	logic [crc16mgc_pkg::CMP_W-1:0] cmp_len_q;
	logic                           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q    <= crc16mgc_pkg::POLY_RESET;
			cmp_len_q <= crc16mgc_pkg::CMP_LEN_RESET;
		end else if (wr_en) begin
			if (paddr[2] == crc16mgc_pkg::REG_POLY) begin
				poly_q <= pwdata[crc16mgc_pkg::CRC_W-1:0];
			end else begin
				cmp_len_q <= pwdata[crc16mgc_pkg::CMP_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == crc16mgc_pkg::REG_CMP_LEN) begin
			prdata = {{(crc16mgc_pkg::APB_DW - crc16mgc_pkg::CMP_W){1'b0}}, cmp_len_q};
		end else begin
			prdata = {{(crc16mgc_pkg::APB_DW - crc16mgc_pkg::CRC_W){1'b0}}, poly_q};
		end
	end

	assign cfg.poly    = poly_q;
	assign cfg.cmp_len = cmp_len_q;

endmodule

>>> design/crc16mgc_core.sv
`timescale 1ns / 1ps
// CRC datapath: input register, one-byte CRC update, accumulator and result register.
// Depends on crc16mgc_pkg for the byte update and compare functions and the config struct.

module crc16mgc_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  crc16mgc_pkg::cfg_t               cfg,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [crc16mgc_pkg::DATA_W-1:0]  in_byte,
	input  logic                             in_first,
	input  logic                             in_last,
	input  logic [crc16mgc_pkg::CRC_W-1:0]   in_rx,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [crc16mgc_pkg::CRC_W-1:0]   out_crc,
	output logic                             out_ok
);

	logic                            valid_s1;
	logic [crc16mgc_pkg::DATA_W-1:0] byte_s1;
	logic                            first_s1;
	logic                            last_s1;
	logic [crc16mgc_pkg::CRC_W-1:0]  rx_s1;

	logic [crc16mgc_pkg::CRC_W-1:0]  acc_q;
	logic                            out_valid_q;
	logic [crc16mgc_pkg::CRC_W-1:0]  out_crc_q;
	logic                            out_ok_q;

	logic [crc16mgc_pkg::CRC_W-1:0]  crc_start;
	logic [crc16mgc_pkg::CRC_W-1:0]  crc_next;
	logic                            s1_go;
	logic                            in_take;

	// A byte that is not the last one never needs the result register.
	assign s1_go    = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_go;
	assign in_take  = in_valid && in_ready;

	assign crc_start = first_s1 ? '0 : acc_q;
	assign crc_next  = crc16mgc_pkg::crc_byte(crc_start, byte_s1, cfg.poly);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1  <= in_byte;
			first_s1 <= in_first;
			last_s1  <= in_last;
			rx_s1    <= in_rx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (s1_go) begin
			acc_q <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			out_crc_q <= crc_next;
			out_ok_q  <= crc16mgc_pkg::crc_match(crc_next, rx_s1, cfg.cmp_len);
		end
	end

	assign out_valid = out_valid_q;
	assign out_crc   = out_crc_q;
	assign out_ok    = out_ok_q;

	a_mid_byte_flows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !last_s1) |-> s1_go)
		else $error("non-final byte stalled in the input register");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_go && last_s1))
		else $error("result appeared without a final byte");

	a_acc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_go |=> $stable(acc_q))
		else $error("accumulator changed without a consumed byte");

	a_result_matches_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (out_crc_q == acc_q))
		else $error("emitted CRC differs from the accumulator");

endmodule
